// ===== rtl/core/tfn_pkg.sv =====
// shared constant for the triangle face normal pipeline
package tfn_pkg;

   // magnitude bits kept after the common right shift
   localparam int REDUCE_BITS = 30;

endpackage

// ===== rtl/core/triangle_face_normal.sv =====
// triangle face normal: from acceptance to result valid an item passes seven datapath stages,
// one stage per quotient bit of the 2*NORMAL_WIDTH+1 bit divider, one stage per root bit of
// the square root and one output stage
// throughput is one item per cycle; a stalled result holds the whole pipeline in place
// synchronous active-high reset clears all valid bits; payload registers are not reset
// triangle face normal pipeline: cross product, normalize, round and saturate
module triangle_face_normal #(
   parameter int COORD_WIDTH  = 24,
   parameter int NORMAL_WIDTH = 16,
   parameter int INDEX_WIDTH  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_WIDTH-1:0]  req_ax,
   input  logic signed [COORD_WIDTH-1:0]  req_ay,
   input  logic signed [COORD_WIDTH-1:0]  req_az,
   input  logic signed [COORD_WIDTH-1:0]  req_bx,
   input  logic signed [COORD_WIDTH-1:0]  req_by_coord,
   input  logic signed [COORD_WIDTH-1:0]  req_bz,
   input  logic signed [COORD_WIDTH-1:0]  req_cx,
   input  logic signed [COORD_WIDTH-1:0]  req_cy,
   input  logic signed [COORD_WIDTH-1:0]  req_cz,
   input  logic        [INDEX_WIDTH-1:0]  req_index_a,
   input  logic        [INDEX_WIDTH-1:0]  req_index_b,
   input  logic        [INDEX_WIDTH-1:0]  req_index_c,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [NORMAL_WIDTH-1:0] rsp_nx,
   output logic signed [NORMAL_WIDTH-1:0] rsp_ny,
   output logic signed [NORMAL_WIDTH-1:0] rsp_nz,
   output logic        [INDEX_WIDTH-1:0]  rsp_out_index_a,
   output logic        [INDEX_WIDTH-1:0]  rsp_out_index_b,
   output logic        [INDEX_WIDTH-1:0]  rsp_out_index_c,
   output logic                           rsp_degenerate
);

   localparam int CW  = COORD_WIDTH;
   localparam int NW  = NORMAL_WIDTH;
   localparam int IW  = INDEX_WIDTH;
   localparam int RB  = tfn_pkg::REDUCE_BITS;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int XW  = PW + 1;
   localparam int MW  = PW;
   localparam int KW  = $clog2(MW + 1);
   localparam int EW  = (MW > RB) ? MW : RB;
   localparam int SQW = 2 * RB;
   localparam int QQW = SQW + 2;
   localparam int TW  = 2 * NW + 1;
   localparam int TPW = 2 * NW + 2;
   localparam int DN  = TW;
   localparam int SN  = NW + 1;
   localparam int RTW = NW + 1;
   localparam int RW  = NW + 3;

   typedef struct packed {
      logic          deg;
      logic [2:0]    neg;
      logic [IW-1:0] ia;
      logic [IW-1:0] ib;
      logic [IW-1:0] ic;
   } side_type;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // front stages
   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                 s5_valid_ff, s6_valid_ff, s7_valid_ff;
   side_type             s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff;
   side_type             s5_side_ff, s6_side_ff, s7_side_ff;
   side_type             s1_side_in, s4_side_in;
   logic signed [DW-1:0] s1_u_ff [3], s1_v_ff [3], s1_u_in [3], s1_v_in [3];
   logic signed [PW-1:0] s2_p_ff [6], s2_p_in [6];
   logic signed [XW-1:0] s3_c_ff [3], s3_c_in [3];
   logic [MW-1:0]        s4_mag_ff [3], s4_mag_in [3];
   logic [KW-1:0]        s4_k_ff, s4_k_in;
   logic [RB-1:0]        s5_m_ff [3], s5_m_in [3];
   logic [SQW-1:0]       s6_sq_ff [3], s6_sq_in [3];
   logic [SQW-1:0]       s7_sq_ff [3];
   logic [QQW-1:0]       s7_den_ff, s7_den_in;

   always_comb begin
      logic signed [XW-1:0] cabs;
      logic [MW-1:0]        ormag;
      logic [KW-1:0]        bitlen;
      logic [EW-1:0]        wide;
      s1_u_in[0] = DW'(req_bx) - DW'(req_ax);
      s1_u_in[1] = DW'(req_by_coord) - DW'(req_ay);
      s1_u_in[2] = DW'(req_bz) - DW'(req_az);
      s1_v_in[0] = DW'(req_cx) - DW'(req_ax);
      s1_v_in[1] = DW'(req_cy) - DW'(req_ay);
      s1_v_in[2] = DW'(req_cz) - DW'(req_az);
      s1_side_in = '{deg: 1'b0, neg: 3'b000, ia: req_index_a, ib: req_index_b,
                     ic: req_index_c};

      s2_p_in[0] = s1_u_ff[1] * s1_v_ff[2];
      s2_p_in[1] = s1_u_ff[2] * s1_v_ff[1];
      s2_p_in[2] = s1_u_ff[2] * s1_v_ff[0];
      s2_p_in[3] = s1_u_ff[0] * s1_v_ff[2];
      s2_p_in[4] = s1_u_ff[0] * s1_v_ff[1];
      s2_p_in[5] = s1_u_ff[1] * s1_v_ff[0];

      for (int j = 0; j < 3; j++) begin
         s3_c_in[j] = XW'(s2_p_ff[2*j]) - XW'(s2_p_ff[2*j+1]);
      end

      s4_side_in = s3_side_ff;
      for (int j = 0; j < 3; j++) begin
         s4_side_in.neg[j] = s3_c_ff[j][XW-1];
         cabs              = s3_c_ff[j][XW-1] ? -s3_c_ff[j] : s3_c_ff[j];
         s4_mag_in[j]      = cabs[MW-1:0];
      end
      ormag  = s4_mag_in[0] | s4_mag_in[1] | s4_mag_in[2];
      bitlen = '0;
      for (int i = 0; i < MW; i++) begin
         if (ormag[i]) begin
            bitlen = KW'(i + 1);
         end
      end
      s4_k_in        = (int'(bitlen) > RB) ? KW'(int'(bitlen) - RB) : '0;
      s4_side_in.deg = (ormag == '0);

      for (int j = 0; j < 3; j++) begin
         wide       = EW'(s4_mag_ff[j]) >> s4_k_ff;
         s5_m_in[j] = wide[RB-1:0];
         s6_sq_in[j] = SQW'(s5_m_ff[j]) * SQW'(s5_m_ff[j]);
      end
      s7_den_in = QQW'(s6_sq_ff[0]) + QQW'(s6_sq_ff[1]) + QQW'(s6_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
         s3_side_ff <= s2_side_ff;
         s4_side_ff <= s4_side_in;
         s5_side_ff <= s4_side_ff;
         s6_side_ff <= s5_side_ff;
         s7_side_ff <= s6_side_ff;
         s1_u_ff    <= s1_u_in;
         s1_v_ff    <= s1_v_in;
         s2_p_ff    <= s2_p_in;
         s3_c_ff    <= s3_c_in;
         s4_mag_ff  <= s4_mag_in;
         s4_k_ff    <= s4_k_in;
         s5_m_ff    <= s5_m_in;
         s6_sq_ff   <= s6_sq_in;
         s7_sq_ff   <= s6_sq_ff;
         s7_den_ff  <= s7_den_in;
      end
   end

   // restoring divider, one quotient bit per stage: floor(m^2 * 4^NW / q)
   logic           d_valid_ff [DN];
   side_type       d_side_ff  [DN];
   logic [QQW-1:0] d_den_ff   [DN];
   logic [QQW-1:0] d_rem_ff   [DN][3];
   logic [TW-1:0]  d_quo_ff   [DN][3];

   for (genvar i = 0; i < DN; i++) begin : g_div
      logic [QQW-1:0] rem_in [3];
      logic [TW-1:0]  quo_in [3];

      if (i == 0) begin : g_first
         always_comb begin
            logic [QQW-1:0] r0;
            logic           qbit;
            for (int j = 0; j < 3; j++) begin
               r0        = QQW'(s7_sq_ff[j]);
               qbit      = (r0 >= s7_den_ff);
               rem_in[j] = qbit ? (r0 - s7_den_ff) : r0;
               quo_in[j] = TW'(qbit);
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[i] <= 1'b0;
            end else if (en) begin
               d_valid_ff[i] <= s7_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               d_side_ff[i] <= s7_side_ff;
               d_den_ff[i]  <= s7_den_ff;
               d_rem_ff[i]  <= rem_in;
               d_quo_ff[i]  <= quo_in;
            end
         end
      end else begin : g_step
         always_comb begin
            logic [QQW:0] r2;
            logic [QQW:0] diff;
            logic         qbit;
            for (int j = 0; j < 3; j++) begin
               r2        = {d_rem_ff[i-1][j], 1'b0};
               diff      = r2 - {1'b0, d_den_ff[i-1]};
               qbit      = (r2 >= {1'b0, d_den_ff[i-1]});
               rem_in[j] = qbit ? diff[QQW-1:0] : r2[QQW-1:0];
               quo_in[j] = {d_quo_ff[i-1][j][TW-2:0], qbit};
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[i] <= 1'b0;
            end else if (en) begin
               d_valid_ff[i] <= d_valid_ff[i-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               d_side_ff[i] <= d_side_ff[i-1];
               d_den_ff[i]  <= d_den_ff[i-1];
               d_rem_ff[i]  <= rem_in;
               d_quo_ff[i]  <= quo_in;
            end
         end
      end
   end

   // restoring square root, one root bit per stage
   logic           s_valid_ff [SN];
   side_type       s_side_ff  [SN];
   logic [TPW-1:0] s_t_ff     [SN][3];
   logic [RW-1:0]  s_rem_ff   [SN][3];
   logic [RTW-1:0] s_root_ff  [SN][3];

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      logic           src_valid;
      side_type       src_side;
      logic [TPW-1:0] src_t    [3];
      logic [RW-1:0]  src_rem  [3];
      logic [RTW-1:0] src_root [3];
      logic [TPW-1:0] t_in     [3];
      logic [RW-1:0]  rem_in   [3];
      logic [RTW-1:0] root_in  [3];

      if (k == 0) begin : g_src_first
         assign src_valid = d_valid_ff[DN-1];
         assign src_side  = d_side_ff[DN-1];
         for (genvar j = 0; j < 3; j++) begin : g_lane
            assign src_t[j]    = TPW'(d_quo_ff[DN-1][j]);
            assign src_rem[j]  = '0;
            assign src_root[j] = '0;
         end
      end else begin : g_src_step
         assign src_valid = s_valid_ff[k-1];
         assign src_side  = s_side_ff[k-1];
         assign src_t     = s_t_ff[k-1];
         assign src_rem   = s_rem_ff[k-1];
         assign src_root  = s_root_ff[k-1];
      end

      always_comb begin
         logic [RW+1:0] rem4;
         logic [RW+1:0] trial;
         logic [RW+1:0] diff;
         logic          ge;
         for (int j = 0; j < 3; j++) begin
            rem4       = {src_rem[j], src_t[j][TPW-1:TPW-2]};
            trial      = (RW + 2)'({src_root[j], 2'b01});
            diff       = rem4 - trial;
            ge         = (rem4 >= trial);
            rem_in[j]  = ge ? diff[RW-1:0] : rem4[RW-1:0];
            root_in[j] = {src_root[j][RTW-2:0], ge};
            t_in[j]    = {src_t[j][TPW-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_valid_ff[k] <= 1'b0;
         end else if (en) begin
            s_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_side_ff[k] <= src_side;
            s_t_ff[k]    <= t_in;
            s_rem_ff[k]  <= rem_in;
            s_root_ff[k] <= root_in;
         end
      end
   end

   // output stage: round, sign, saturate
   logic                 rsp_valid_ff;
   side_type             rsp_side_ff;
   logic signed [NW-1:0] rsp_n_ff [3], rsp_n_in [3];

   always_comb begin
      logic [RTW:0]   rsum;
      logic [RTW-1:0] r;
      logic [RTW-1:0] rneg;
      side_type       sd;
      sd = s_side_ff[SN-1];
      for (int j = 0; j < 3; j++) begin
         rsum = (RTW + 1)'(s_root_ff[SN-1][j]) + (RTW + 1)'(1);
         r    = rsum[RTW:1];
         rneg = RTW'(0) - r;
         if (sd.deg) begin
            rsp_n_in[j] = '0;
         end else if (sd.neg[j]) begin
            rsp_n_in[j] = rneg[NW-1:0];
         end else if (r[NW-1]) begin
            rsp_n_in[j] = {1'b0, {(NW-1){1'b1}}};
         end else begin
            rsp_n_in[j] = r[NW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s_valid_ff[SN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_side_ff <= s_side_ff[SN-1];
         rsp_n_ff    <= rsp_n_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_nx          = rsp_n_ff[0];
   assign rsp_ny          = rsp_n_ff[1];
   assign rsp_nz          = rsp_n_ff[2];
   assign rsp_out_index_a = rsp_side_ff.ia;
   assign rsp_out_index_b = rsp_side_ff.ib;
   assign rsp_out_index_c = rsp_side_ff.ic;
   assign rsp_degenerate  = rsp_side_ff.deg;

`ifndef SYNTHESIS
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_nx == '0 && rsp_ny == '0 && rsp_nz == '0)
      else $error("degenerate item with nonzero normal");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_nx != '0 || rsp_ny != '0 || rsp_nz != '0)
      else $error("non-degenerate item with zero normal");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted while result is stalled");
`endif

endmodule

// ===== verif/triangle_face_normal_checker.sv =====
// checker for the triangle face normal block: predicts each normal and compares results
module triangle_face_normal_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [23:0] req_ax,
   input  logic signed [23:0] req_ay,
   input  logic signed [23:0] req_az,
   input  logic signed [23:0] req_bx,
   input  logic signed [23:0] req_by_coord,
   input  logic signed [23:0] req_bz,
   input  logic signed [23:0] req_cx,
   input  logic signed [23:0] req_cy,
   input  logic signed [23:0] req_cz,
   input  logic        [23:0] req_index_a,
   input  logic        [23:0] req_index_b,
   input  logic        [23:0] req_index_c,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_nx,
   input  logic signed [15:0] rsp_ny,
   input  logic signed [15:0] rsp_nz,
   input  logic        [23:0] rsp_out_index_a,
   input  logic        [23:0] rsp_out_index_b,
   input  logic        [23:0] rsp_out_index_c,
   input  logic               rsp_degenerate,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] nx, ny, nz;
      logic [23:0]        ia, ib, ic;
      logic               degen;
   } normal_type;

   normal_type expected_normals[$];

   function automatic longint unsigned scaled_component(longint unsigned m,
         longint unsigned q);
      longint unsigned lo, hi, mid, a, s;
      logic [127:0]    rhs, lhs;
      s = 64'd32768;
      rhs = (2 * s * m) * (2 * s * m);
      lo = 0;
      hi = s;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         a = 2 * mid - 1;
         lhs = 128'(a * a) * 128'(q);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic normal_type face_normal(logic signed [23:0] p[9],
         logic [23:0] ia, logic [23:0] ib, logic [23:0] ic);
      normal_type r;
      logic signed [63:0]  u[3], v[3];
      logic signed [127:0] c[3];
      logic [127:0]        mag[3], big;
      longint unsigned     m[3], q, n;
      logic signed [15:0]  o[3];
      for (int j = 0; j < 3; j++) begin
         u[j] = 64'(p[3 + j]) - 64'(p[j]);
         v[j] = 64'(p[6 + j]) - 64'(p[j]);
      end
      c[0] = 128'(u[1]) * 128'(v[2]) - 128'(u[2]) * 128'(v[1]);
      c[1] = 128'(u[2]) * 128'(v[0]) - 128'(u[0]) * 128'(v[2]);
      c[2] = 128'(u[0]) * 128'(v[1]) - 128'(u[1]) * 128'(v[0]);
      big = '0;
      for (int j = 0; j < 3; j++) begin
         mag[j] = c[j] < 0 ? -c[j] : c[j];
         if (mag[j] > big) big = mag[j];
      end
      r.ia = ia;
      r.ib = ib;
      r.ic = ic;
      if (big == 0) begin
         r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
         return r;
      end
      while (big >= (128'd1 << tfn_pkg::REDUCE_BITS)) begin
         big = big >> 1;
         for (int j = 0; j < 3; j++) mag[j] = mag[j] >> 1;
      end
      q = 0;
      for (int j = 0; j < 3; j++) begin
         m[j] = mag[j][63:0];
         q += m[j] * m[j];
      end
      for (int j = 0; j < 3; j++) begin
         n = scaled_component(m[j], q);
         if (c[j] < 0) o[j] = 16'(-n);
         else o[j] = n > 32767 ? 16'sd32767 : 16'(n);
      end
      r.nx = o[0]; r.ny = o[1]; r.nz = o[2]; r.degen = 1'b0;
      return r;
   endfunction

   initial errors = 0;
   initial pending = 0;

   always @(posedge clock) begin
      normal_type want, got;
      logic signed [23:0] p[9];
      if (!reset && req_valid && !req_stall) begin
         p = '{req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz, req_cx, req_cy,
               req_cz};
         expected_normals.push_back(face_normal(p, req_index_a, req_index_b,
            req_index_c));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_nx, rsp_ny, rsp_nz, rsp_out_index_a, rsp_out_index_b,
                 rsp_out_index_c, rsp_degenerate};
         if (expected_normals.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_normals.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
      pending = expected_normals.size();
   end
endmodule

// ===== verif/triangle_face_normal_test.sv =====
// testbench top for the triangle face normal block: stimulus, idling and verdict
module triangle_face_normal_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock, reset;
   logic               req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [23:0] req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz;
   logic signed [23:0] req_cx, req_cy, req_cz;
   logic        [23:0] req_index_a, req_index_b, req_index_c;
   logic signed [15:0] rsp_nx, rsp_ny, rsp_nz;
   logic        [23:0] rsp_out_index_a, rsp_out_index_b, rsp_out_index_c;
   logic               rsp_degenerate;
   int                 errors, pending, send_idle, recv_idle, quiet;
   logic signed [23:0] tri_q[$][9];

   triangle_face_normal u_top (.*);

   triangle_face_normal_checker u_check (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'sh7fffff;
         1: return 24'sh800000;
         2: return 24'($urandom_range(0, 63)) - 24'sd32;
         3: return 24'($urandom_range(0, 8191)) - 24'sd4096;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [23:0] t[9];
      logic signed [23:0] hi, lo;
      hi = 24'sh7fffff;
      lo = 24'sh800000;
      tri_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      tri_q.push_back('{1, 2, 3, 1, 2, 3, 1, 2, 3});
      tri_q.push_back('{0, 0, 0, 4096, 0, 0, 0, 4096, 0});
      tri_q.push_back('{0, 0, 0, 0, 4096, 0, 4096, 0, 0});
      tri_q.push_back('{0, 0, 0, 0, 0, 4096, 4096, 0, 0});
      tri_q.push_back('{0, 0, 0, 4096, 0, 0, 0, 0, 4096});
      tri_q.push_back('{0, 0, 0, 1, 2, 3, 2, 4, 6});
      tri_q.push_back('{lo, lo, lo, hi, lo, lo, lo, hi, lo});
      tri_q.push_back('{hi, hi, hi, lo, hi, hi, hi, lo, hi});
      tri_q.push_back('{lo, lo, lo, hi, hi, lo, lo, hi, hi});
      tri_q.push_back('{hi, lo, hi, lo, hi, lo, hi, hi, lo});
      tri_q.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0});
      tri_q.push_back('{0, 0, 0, 1, 1, 0, 1, 0, 1});
      tri_q.push_back('{-1, -1, -1, 0, 0, 0, 1, 1, 0});
      for (int i = 0; i < 700; i++) begin
         foreach (t[k]) t[k] = rand_coord();
         if ($urandom_range(0, 19) == 0) t[6:8] = t[3:5];
         tri_q.push_back(t);
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      quiet <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ? 0 : quiet + 1;
      if (quiet > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int n;
      reset = 1; req_valid = 0; rsp_stall = 0; quiet = 0;
      {req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz, req_cx, req_cy, req_cz} = '0;
      {req_index_a, req_index_b, req_index_c} = '0;
      send_idle = 14; recv_idle = 61;
      repeat (2) @(posedge clock);
      reset <= 0;
      n = 0;
      while (tri_q.size() > 0) begin
         if (n == 240) begin send_idle = 61; recv_idle = 14; end
         if (n == 480) begin send_idle = 0; recv_idle = 0; end
         if ($urandom_range(0, 99) < send_idle) begin
            req_valid <= 0;
            @(posedge clock);
         end else begin
            {req_ax, req_ay, req_az} <= {tri_q[0][0], tri_q[0][1], tri_q[0][2]};
            {req_bx, req_by_coord, req_bz} <= {tri_q[0][3], tri_q[0][4], tri_q[0][5]};
            {req_cx, req_cy, req_cz} <= {tri_q[0][6], tri_q[0][7], tri_q[0][8]};
            req_index_a <= (n % 3 == 0) ? 24'hffffff : (n % 3 == 1) ? 24'h0 : 24'($urandom);
            req_index_b <= 24'($urandom);
            req_index_c <= (n % 2) ? 24'hffffff : 24'($urandom);
            req_valid <= 1;
            void'(tri_q.pop_front());
            n++;
            do @(posedge clock); while (req_stall);
         end
      end
      req_valid <= 0;
      while (pending > 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/tfn_pkg.sv
rtl/core/triangle_face_normal.sv
verif/triangle_face_normal_checker.sv
verif/triangle_face_normal_test.sv
